// ----- rtl/task_banked_memory_mapper_defines.svh -----
// Assertion macros shared by the banked memory mapper RTL.
`ifndef TASK_BANKED_MEMORY_MAPPER_DEFINES_SVH
`define TASK_BANKED_MEMORY_MAPPER_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define TBMM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define TBMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tbmm_pkg.sv -----
// Types and decode constants for the task banked memory mapper.
package tbmm_pkg;

    // Where one bus access is routed
    typedef enum logic [2:0] {
        ROUTE_PASS       = 3'd0,
        ROUTE_ROM        = 3'd1,
        ROUTE_EXT_RAM    = 3'd2,
        ROUTE_SPI        = 3'd3,
        ROUTE_MAP_REG    = 3'd4,
        ROUTE_SER_STATUS = 3'd5,
        ROUTE_SER_DATA   = 3'd6
    } route_t;

    // Access kind
    localparam logic FUNC_WRITE = 1'b1;

    // Decode addresses and masks
    localparam logic [15:0] ADDR_ROM_SETTING = 16'hFF64;
    localparam logic [15:0] ADDR_SPI_BASE    = 16'hFF6C;
    localparam logic [15:0] MASK_SPI         = 16'hFFFC;
    localparam logic [15:0] ADDR_BANK_WIN    = 16'hFFA0;
    localparam logic [15:0] MASK_WIN16       = 16'hFFF0;
    localparam logic [15:0] ADDR_INIT0       = 16'hFF90;
    localparam logic [15:0] ADDR_INIT1       = 16'hFF91;
    localparam logic [15:0] ADDR_VECTORS     = 16'hFFF0;
    localparam logic [7:0]  PAGE_IO          = 8'hFF;
    localparam logic [7:0]  PAGE_CONST       = 8'hFE;
    localparam logic [2:0]  SEG_TOP          = 3'd7;

    // Bank register defaults
    localparam logic [5:0]  BANK_FIXED       = 6'h3F;

    // Serial port register selects (address bits 1:0)
    localparam logic [1:0]  SER_SEL_STATUS   = 2'd1;
    localparam logic [1:0]  SER_SEL_DATA     = 2'd2;

    // One bus access request
    typedef struct packed {
        logic        func;
        logic [15:0] address;
        logic [7:0]  data_in;
        logic        rom_window;
        logic        io_window;
    } req_t;

    // Routing result for one access
    typedef struct packed {
        route_t      route;
        logic [18:0] target_addr;
        logic [7:0]  read_data;
        logic        ext_ram_select;
    } rsp_t;

endpackage

// ----- rtl/task_banked_memory_mapper.sv -----
// Task banked memory mapper: routes CPU bus accesses and holds the bank registers.
//
// Request channel (req_valid / req_stall / req) carries one bus access: kind,
// address, data, ROM-window and I/O-window strobes. Response channel
// (rsp_valid / rsp_stall / rsp) returns the route, the translated address,
// the data to drive back and the external RAM select, one per request.
// Throughput is one request per cycle while req_stall is low; the whole
// decode and bank lookup sits between the request port and the response
// register, and register writes made by a request are seen by the next one.
// A two-entry output stage (response register plus skid register) lets a
// request be accepted while the response register waits on rsp_stall;
// req_stall is high exactly while both entries hold a response.
// cfg_wr_en / cfg_wr_data write the serial-port-present flag; the user must do
// so only while idle, which the block itself does not enforce. Reset sets all
// sixteen bank registers to 63, clears task select, mapper enable, constant-RAM
// enable, the ROM setting and the serial flag, and empties the output stage.
module task_banked_memory_mapper (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic            cfg_wr_data,
    input  logic            req_valid,
    output logic            req_stall,
    input  tbmm_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output tbmm_pkg::rsp_t  rsp
);

`include "task_banked_memory_mapper_defines.svh"

    // Mapper state
    logic [5:0]     bank_map_reg [16];
    logic           task_select_reg;
    logic           map_enable_reg;
    logic           const_ram_enable_reg;
    logic [4:0]     rom_setting_reg;
    logic           serial_present_reg;

    // Output stage
    tbmm_pkg::rsp_t rsp_reg;
    logic           rsp_valid_reg;
    tbmm_pkg::rsp_t skid_reg;
    logic           skid_valid_reg;

    // Decode signals
    logic           req_fire;
    logic           is_write;
    logic [15:0]    a;
    logic           hit_spi;
    logic           hit_bank_win;
    logic           hit_init0;
    logic           hit_init1;
    logic           hit_rom_set;
    logic [3:0]     bank_idx;
    logic [5:0]     bank_rd;
    logic           ram_range;
    logic           fixed_const;
    logic           fixed_vec;
    logic [5:0]     ram_bank;
    logic [12:0]    ram_off;
    logic           ram_hit;
    tbmm_pkg::rsp_t rsp_next;

    assign req_fire  = req_valid && !req_stall;
    assign req_stall = skid_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Address decode
    assign is_write     = (req.func == tbmm_pkg::FUNC_WRITE);
    assign a            = req.address;
    assign hit_spi      = ((a & tbmm_pkg::MASK_SPI) == tbmm_pkg::ADDR_SPI_BASE);
    assign hit_bank_win = ((a & tbmm_pkg::MASK_WIN16) == tbmm_pkg::ADDR_BANK_WIN);
    assign hit_init0    = is_write && (a == tbmm_pkg::ADDR_INIT0);
    assign hit_init1    = is_write && (a == tbmm_pkg::ADDR_INIT1);
    assign hit_rom_set  = is_write && (a == tbmm_pkg::ADDR_ROM_SETTING)
                          && !rom_setting_reg[4];

    // Single bank register read: window entry on readback, else task/segment
    assign bank_idx = hit_bank_win ? a[3:0] : {task_select_reg, a[15:13]};
    assign bank_rd  = bank_map_reg[bank_idx];

    // Mapped RAM translation
    assign fixed_vec   = const_ram_enable_reg && (a >= tbmm_pkg::ADDR_VECTORS);
    assign ram_range   = map_enable_reg && ((a[15:8] != tbmm_pkg::PAGE_IO) || fixed_vec);
    assign fixed_const = const_ram_enable_reg && (a[15:8] == tbmm_pkg::PAGE_CONST);
    assign ram_bank    = (fixed_const || fixed_vec) ? tbmm_pkg::BANK_FIXED : bank_rd;
    assign ram_off     = {a[12:9], a[8] | fixed_const, a[7:0]};
    assign ram_hit     = ram_range && ((ram_bank != tbmm_pkg::BANK_FIXED) || fixed_const
                         || fixed_vec || (a[15:13] == tbmm_pkg::SEG_TOP));

    // Route selection in priority order
    always_comb
    begin
        rsp_next                = '0;
        rsp_next.route          = tbmm_pkg::ROUTE_PASS;
        rsp_next.read_data      = req.data_in;
        if (req.rom_window)
        begin
            rsp_next.route = tbmm_pkg::ROUTE_ROM;
            if (rom_setting_reg[3])
                rsp_next.target_addr = {3'b000, rom_setting_reg[2:1], a[13:0]};
            else
                rsp_next.target_addr = {3'b000, rom_setting_reg[2:0], a[12:0]};
        end
        else if (hit_spi)
        begin
            rsp_next.route       = tbmm_pkg::ROUTE_SPI;
            rsp_next.target_addr = {17'd0, a[1:0]};
        end
        else if (hit_bank_win)
        begin
            rsp_next.route = tbmm_pkg::ROUTE_MAP_REG;
            if (!is_write)
                rsp_next.read_data = {2'b00, bank_rd};
        end
        else if (hit_init0 || hit_init1)
        begin
            rsp_next.route = tbmm_pkg::ROUTE_PASS;
        end
        else if (ram_hit)
        begin
            rsp_next.route          = tbmm_pkg::ROUTE_EXT_RAM;
            rsp_next.target_addr    = {ram_bank, ram_off};
            rsp_next.ext_ram_select = 1'b1;
        end
        else if (req.io_window && serial_present_reg)
        begin
            if (!is_write && (a[1:0] == tbmm_pkg::SER_SEL_STATUS))
                rsp_next.route = tbmm_pkg::ROUTE_SER_STATUS;
            else if (a[1:0] == tbmm_pkg::SER_SEL_DATA)
                rsp_next.route = tbmm_pkg::ROUTE_SER_DATA;
        end
    end

    // Mapper register updates on accepted requests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                bank_map_reg[i] <= tbmm_pkg::BANK_FIXED;
            task_select_reg      <= 1'b0;
            map_enable_reg       <= 1'b0;
            const_ram_enable_reg <= 1'b0;
            rom_setting_reg      <= 5'd0;
        end
        else if (req_fire && !req.rom_window)
        begin
            if (hit_rom_set)
                rom_setting_reg <= req.data_in[4:0];
            if (!hit_spi && hit_bank_win && is_write)
                bank_map_reg[a[3:0]] <= req.data_in[5:0];
            if (!hit_spi && !hit_bank_win && hit_init0)
            begin
                const_ram_enable_reg <= req.data_in[3];
                map_enable_reg       <= req.data_in[6];
            end
            if (!hit_spi && !hit_bank_win && hit_init1)
                task_select_reg <= req.data_in[0];
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            serial_present_reg <= 1'b0;
        else if (cfg_wr_en)
            serial_present_reg <= cfg_wr_data;
    end

    // Output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!rsp_valid_reg || !rsp_stall)
        begin
            if (skid_valid_reg)
            begin
                rsp_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                rsp_valid_reg <= req_fire;
            end
        end
        else if (req_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (!rsp_valid_reg || !rsp_stall)
        begin
            if (skid_valid_reg)
                rsp_reg <= skid_reg;
            else if (req_fire)
                rsp_reg <= rsp_next;
        end
        else if (req_fire)
        begin
            skid_reg <= rsp_next;
        end
    end

    // Checks
    `TBMM_ASSERT_NOW(a_ram_sel_match, rsp_valid_reg,
        rsp_reg.ext_ram_select == (rsp_reg.route == tbmm_pkg::ROUTE_EXT_RAM),
        "ext_ram_select disagrees with route")
    `TBMM_ASSERT_NOW(a_skid_needs_out, skid_valid_reg, rsp_valid_reg,
        "skid entry held while response register empty")
    `TBMM_ASSERT_NOW(a_addr_zero, rsp_valid_reg && rsp_reg.route != tbmm_pkg::ROUTE_ROM
        && rsp_reg.route != tbmm_pkg::ROUTE_EXT_RAM && rsp_reg.route != tbmm_pkg::ROUTE_SPI,
        rsp_reg.target_addr == 19'd0, "target address set on a route without one")
    `TBMM_ASSERT_NEXT(a_rom_lock, rom_setting_reg[4],
        rom_setting_reg == $past(rom_setting_reg), "locked ROM setting changed")
    `TBMM_ASSERT_NEXT(a_task_write, req_fire && !req.rom_window && is_write
        && a == tbmm_pkg::ADDR_INIT1,
        task_select_reg == $past(req.data_in[0]), "task select write lost")

endmodule

// ----- bench/tbmm_route_checker.sv -----
// Route checker for the banked memory mapper: predicts each request's routing and compares.
`timescale 1ns / 1ps

module tbmm_route_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic            cfg_wr_data,
    input  logic            req_valid,
    input  logic            req_stall,
    input  tbmm_pkg::req_t  req,
    input  logic            rsp_valid,
    input  logic            rsp_stall,
    input  tbmm_pkg::rsp_t  rsp,
    output int              fail_count,
    output int              n_expected
);

    // Shadow copy of the mapper state
    logic [5:0] bank_regs [16];
    logic       task_sel;
    logic       map_en;
    logic       const_ram_en;
    logic [4:0] rom_cfg;
    logic       serial_fitted;

    tbmm_pkg::rsp_t expected_routes [$];
    tbmm_pkg::rsp_t want;

    initial fail_count = 0;

    // Routing of one bus request; updates the shadow registers it writes
    function automatic tbmm_pkg::rsp_t route_access(tbmm_pkg::req_t a);
        tbmm_pkg::rsp_t e;
        logic           wr;
        logic [5:0]     bank;
        logic [12:0]    off;
        logic           fixed;
        logic           vec_hit;

        wr               = (a.func == tbmm_pkg::FUNC_WRITE);
        e.route          = tbmm_pkg::ROUTE_PASS;
        e.target_addr    = '0;
        e.read_data      = a.data_in;
        e.ext_ram_select = 1'b0;
        vec_hit          = ((a.address & tbmm_pkg::MASK_WIN16) == tbmm_pkg::ADDR_VECTORS);

        // ROM window strobe wins over everything
        if (a.rom_window)
        begin
            e.route = tbmm_pkg::ROUTE_ROM;
            if (rom_cfg[3])
                e.target_addr = {3'b000, rom_cfg[2:1], a.address[13:0]};
            else
                e.target_addr = {3'b000, rom_cfg[2:0], a.address[12:0]};
            return e;
        end

        // ROM setting write, ignored once locked; decoding continues
        if (wr && a.address == tbmm_pkg::ADDR_ROM_SETTING && !rom_cfg[4])
            rom_cfg = a.data_in[4:0];

        if ((a.address & tbmm_pkg::MASK_SPI) == tbmm_pkg::ADDR_SPI_BASE)
        begin
            e.route       = tbmm_pkg::ROUTE_SPI;
            e.target_addr = {17'd0, a.address[1:0]};
            return e;
        end

        // Bank register window: entry index is address bits 3:0
        if ((a.address & tbmm_pkg::MASK_WIN16) == tbmm_pkg::ADDR_BANK_WIN)
        begin
            e.route = tbmm_pkg::ROUTE_MAP_REG;
            if (wr)
                bank_regs[a.address[3:0]] = a.data_in[5:0];
            else
                e.read_data = {2'b00, bank_regs[a.address[3:0]]};
            return e;
        end

        if (wr && a.address == tbmm_pkg::ADDR_INIT0)
        begin
            const_ram_en = a.data_in[3];
            map_en       = a.data_in[6];
            return e;
        end
        if (wr && a.address == tbmm_pkg::ADDR_INIT1)
        begin
            task_sel = a.data_in[0];
            return e;
        end

        // Mapped RAM; bank 63 outside the top segment falls through
        if (map_en && (a.address[15:8] != tbmm_pkg::PAGE_IO || (vec_hit && const_ram_en)))
        begin
            off   = a.address[12:0];
            fixed = 1'b0;
            if (const_ram_en && a.address[15:8] == tbmm_pkg::PAGE_CONST)
            begin
                fixed  = 1'b1;
                bank   = tbmm_pkg::BANK_FIXED;
                off[8] = 1'b1;
            end
            else if (const_ram_en && vec_hit)
            begin
                fixed = 1'b1;
                bank  = tbmm_pkg::BANK_FIXED;
            end
            else
            begin
                bank = bank_regs[{task_sel, a.address[15:13]}];
            end
            if (bank != tbmm_pkg::BANK_FIXED || fixed || a.address[15:13] == tbmm_pkg::SEG_TOP)
            begin
                e.route          = tbmm_pkg::ROUTE_EXT_RAM;
                e.target_addr    = {bank, off};
                e.ext_ram_select = 1'b1;
                return e;
            end
        end

        // Serial port in the cartridge I/O area
        if (a.io_window && serial_fitted)
        begin
            if (!wr && a.address[1:0] == tbmm_pkg::SER_SEL_STATUS)
                e.route = tbmm_pkg::ROUTE_SER_STATUS;
            else if (a.address[1:0] == tbmm_pkg::SER_SEL_DATA)
                e.route = tbmm_pkg::ROUTE_SER_DATA;
        end
        return e;
    endfunction

    task automatic check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s expected %0h got %0h", $time, field, want_v, got_v);
            fail_count++;
        end
    endtask

    // Compare accepted responses, then predict the request taken at this edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                bank_regs[i] = tbmm_pkg::BANK_FIXED;
            task_sel      = 1'b0;
            map_en        = 1'b0;
            const_ram_en  = 1'b0;
            rom_cfg       = '0;
            serial_fitted = 1'b0;
            expected_routes.delete();
            n_expected <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_routes.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none got %0h", $time, rsp);
                    fail_count++;
                end
                else
                begin
                    want = expected_routes.pop_front();
                    check_field("route", 32'(want.route), 32'(rsp.route));
                    check_field("target_addr", 32'(want.target_addr), 32'(rsp.target_addr));
                    check_field("read_data", 32'(want.read_data), 32'(rsp.read_data));
                    check_field("ext_ram_select", 32'(want.ext_ram_select),
                                32'(rsp.ext_ram_select));
                end
            end
            // a request taken at this edge still sees the old serial flag
            if (req_valid && !req_stall)
                expected_routes.push_back(route_access(req));
            if (cfg_wr_en)
                serial_fitted = cfg_wr_data;
            n_expected <= expected_routes.size();
        end
    end

endmodule

// ----- bench/task_banked_memory_mapper_tb.sv -----
// Testbench top for the banked memory mapper: drives bus requests and reports the verdict.
`timescale 1ns / 1ps

module task_banked_memory_mapper_tb;

    logic           clk         = 1'b0;
    logic           rst_n       = 1'b0;
    logic           cfg_wr_en   = 1'b0;
    logic           cfg_wr_data = 1'b0;
    logic           req_valid   = 1'b0;
    logic           req_stall;
    tbmm_pkg::req_t bus_req     = '0;
    logic           rsp_valid;
    logic           rsp_stall   = 1'b0;
    tbmm_pkg::rsp_t rsp;

    int   fail_count;
    int   n_expected;
    int   idle_pct  = 0;
    int   stall_pct = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task_banked_memory_mapper i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (bus_req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp)
    );

    tbmm_route_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (bus_req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .n_expected  (n_expected)
    );

    // Receiver back-pressure
    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic tbmm_pkg::req_t access(logic f, logic [15:0] addr, logic [7:0] d,
                                              logic romw, logic iow);
        tbmm_pkg::req_t r;
        r.func       = f;
        r.address    = addr;
        r.data_in    = d;
        r.rom_window = romw;
        r.io_window  = iow;
        return r;
    endfunction

    // Random request, biased toward the mapper registers so RAM mapping gets exercised
    function automatic tbmm_pkg::req_t random_access(bit allow_lock);
        tbmm_pkg::req_t r;
        int             pick;
        r.func       = 1'($urandom_range(1));
        r.data_in    = 8'($urandom_range(255));
        r.rom_window = ($urandom_range(99) < 8);
        r.io_window  = ($urandom_range(99) < 30);
        r.address    = 16'($urandom_range(16'hFEFF));
        pick         = $urandom_range(99);
        if (pick < 22)
        begin
            r.address = {tbmm_pkg::ADDR_BANK_WIN[15:4], 4'($urandom_range(15))};
            if ($urandom_range(3) == 0)
                r.data_in[5:0] = tbmm_pkg::BANK_FIXED;
        end
        else if (pick < 30)
        begin
            r.address    = tbmm_pkg::ADDR_INIT0;
            r.data_in[6] = ($urandom_range(3) != 0);
        end
        else if (pick < 35)
        begin
            r.address = tbmm_pkg::ADDR_INIT1;
        end
        else if (pick < 39)
        begin
            // this branch keeps the lock bit clear until the last phase
            r.address = tbmm_pkg::ADDR_ROM_SETTING;
            if (!allow_lock)
                r.data_in[4] = 1'b0;
        end
        else if (pick < 44)
        begin
            r.address = tbmm_pkg::ADDR_SPI_BASE | 16'($urandom_range(3));
        end
        else if (pick < 52)
        begin
            r.address = {tbmm_pkg::PAGE_CONST, 8'($urandom_range(255))};
        end
        else if (pick < 58)
        begin
            r.address = {tbmm_pkg::ADDR_VECTORS[15:4], 4'($urandom_range(15))};
        end
        else if (pick >= 90)
        begin
            r.address = 16'($urandom_range(16'hFFFF));
        end
        return r;
    endfunction

    // Present one request and hold it until accepted
    task automatic send_req(tbmm_pkg::req_t r);
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        bus_req   <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait for every outstanding response
    task automatic drain;
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (n_expected != 0);
    endtask

    task automatic write_serial_flag(logic v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests with the serial port fitted
        write_serial_flag(1'b1);
        send_req(access(1'b0, 16'h0000, 8'h00, 1'b0, 1'b0));
        send_req(access(1'b0, 16'h1234, 8'hA5, 1'b1, 1'b0));
        send_req(access(1'b1, tbmm_pkg::ADDR_ROM_SETTING, 8'h0B, 1'b0, 1'b0));
        send_req(access(1'b1, 16'hFFFF, 8'hFF, 1'b1, 1'b1));
        send_req(access(1'b1, tbmm_pkg::ADDR_ROM_SETTING, 8'hE5, 1'b0, 1'b0));
        send_req(access(1'b0, 16'h3FFF, 8'h5A, 1'b1, 1'b0));
        send_req(access(1'b0, tbmm_pkg::ADDR_SPI_BASE, 8'h11, 1'b1, 1'b1));
        send_req(access(1'b1, tbmm_pkg::ADDR_SPI_BASE | 16'h3, 8'h22, 1'b0, 1'b1));
        send_req(access(1'b1, tbmm_pkg::ADDR_BANK_WIN, 8'hC5, 1'b0, 1'b0));
        send_req(access(1'b0, tbmm_pkg::ADDR_BANK_WIN, 8'hFF, 1'b0, 1'b0));
        send_req(access(1'b1, tbmm_pkg::ADDR_BANK_WIN | 16'hF, 8'h3F, 1'b0, 1'b0));
        send_req(access(1'b0, tbmm_pkg::ADDR_BANK_WIN | 16'hF, 8'h00, 1'b0, 1'b0));
        send_req(access(1'b1, tbmm_pkg::ADDR_BANK_WIN | 16'h7, 8'h00, 1'b0, 1'b0));
        send_req(access(1'b1, tbmm_pkg::ADDR_INIT0, 8'h48, 1'b0, 1'b0));
        send_req(access(1'b0, tbmm_pkg::ADDR_INIT0, 8'h00, 1'b0, 1'b0));
        send_req(access(1'b0, 16'h0000, 8'h33, 1'b0, 1'b0));
        send_req(access(1'b0, 16'hE000, 8'h44, 1'b0, 1'b1));
        send_req(access(1'b0, 16'hFE12, 8'h55, 1'b0, 1'b0));
        send_req(access(1'b1, 16'hFFF8, 8'h66, 1'b0, 1'b0));
        send_req(access(1'b1, tbmm_pkg::ADDR_INIT1, 8'h01, 1'b0, 1'b0));
        // task one: segment 7 holds bank 63 and maps, segment 1 falls through
        send_req(access(1'b0, 16'hE123, 8'h77, 1'b0, 1'b0));
        send_req(access(1'b0, 16'h2001, 8'h88, 1'b0, 1'b1));
        send_req(access(1'b1, 16'h4002, 8'h99, 1'b0, 1'b1));
        send_req(access(1'b1, tbmm_pkg::ADDR_INIT0, 8'h00, 1'b0, 1'b0));
        send_req(access(1'b1, 16'hFF01, 8'hAA, 1'b0, 1'b1));
        send_req(access(1'b0, 16'hFF22, 8'hBB, 1'b0, 1'b1));
        send_req(access(1'b1, tbmm_pkg::ADDR_INIT1, 8'h00, 1'b0, 1'b0));

        // Random phases: four idle patterns, each with the serial port absent then fitted
        for (int p = 0; p < 8; p++)
        begin
            drain();
            write_serial_flag(p[2]);
            case (p % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 84;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 84;
                end
                default:
                begin
                    idle_pct  = 13;
                    stall_pct = 13;
                end
            endcase
            repeat (119)
                send_req(random_access(p == 7));
        end

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tbmm_pkg.sv
rtl/task_banked_memory_mapper.sv
bench/tbmm_route_checker.sv
bench/task_banked_memory_mapper_tb.sv
